[rtl/gregorian_date_arithmetic_macros.svh]
// assertion macros for the gregorian date arithmetic block
// expects clk and rst_n in the scope of each use; SYNTH removes the checks
`ifndef GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`define GREGORIAN_DATE_ARITHMETIC_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define GDA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gda check failed");
// next-cycle implication
`define GDA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gda check failed");
`else
`define GDA_ASSERT_IMP(lbl, ante, cons)
`define GDA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/gda_pkg.sv]
// types, constants and calendar helpers for the gregorian date arithmetic block
// no dependencies
`default_nettype none

package gda_pkg;

    localparam int MAX_YEAR  = 9999;
    localparam int NUM_W     = 22;
    localparam int CYC400    = 146097;
    localparam int CYC100    = 36524;
    localparam int CYC4      = 1461;
    localparam int YEAR_LEN  = 365;
    localparam int COUNT_MAX = 4194303;
    // floor(x / 100) == (x * RECIP100) >> RECIP_SH for every 14-bit x
    localparam int RECIP100  = 5243;
    localparam int RECIP_SH  = 19;

    localparam int REPL_YEAR = 1900;
    localparam int REPL_NUM  = (REPL_YEAR - 1) * 365 + (REPL_YEAR - 1) / 4
                               - (REPL_YEAR - 1) / 100 + (REPL_YEAR - 1) / 400;
    localparam int MAX_LEAP  = (((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0))
                               || ((MAX_YEAR % 400) == 0) ? 1 : 0;
    // day number of 31 december of the last year
    localparam int LIMIT_NUM = (MAX_YEAR - 1) * 365 + (MAX_YEAR - 1) / 4
                               - (MAX_YEAR - 1) / 100 + (MAX_YEAR - 1) / 400
                               + 364 + MAX_LEAP;

    localparam logic [1:0] ACT_ADD  = 2'd0;
    localparam logic [1:0] ACT_SUB  = 2'd1;
    localparam logic [1:0] ACT_DIFF = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_SAT     = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [19:0] offset_days;
        logic [13:0] other_year;
        logic [3:0]  other_month;
        logic [4:0]  other_day;
    } gda_in_t;

    typedef struct packed {
        logic [13:0] res_year;
        logic [3:0]  res_month;
        logic [4:0]  res_day;
        logic [21:0] day_count;
        logic [1:0]  status;
    } gda_out_t;

    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LOAD   = 4'd1,
        OP_MUL    = 4'd2,
        OP_CHECK  = 4'd3,
        OP_NUM    = 4'd4,
        OP_OTHER  = 4'd5,
        OP_DIFF   = 4'd6,
        OP_ARITH  = 4'd7,
        OP_D400   = 4'd8,
        OP_D100   = 4'd9,
        OP_D4     = 4'd10,
        OP_D1     = 4'd11,
        OP_LEAPQ  = 4'd12,
        OP_LEAP   = 4'd13,
        OP_MON    = 4'd14,
        OP_FINISH = 4'd15
    } gda_op_t;

    typedef struct packed {
        gda_op_t op;
    } gda_cmd_t;

    typedef struct packed {
        logic is_diff;
        logic go400;
        logic go100;
        logic go4;
        logic go1;
        logic gomon;
    } gda_stat_t;

    // leap year from the year and its hundreds quotient
    function automatic logic leap_of(input logic [13:0] y, input logic [7:0] q);
        logic [14:0] q100;
        begin
            q100 = {7'b0, q} * 15'd100;
            leap_of = (y[1:0] == 2'b00) && (({1'b0, y} != q100) || (q[1:0] == 2'b00));
        end
    endfunction

    function automatic logic [4:0] days_in(input logic lp, input logic [3:0] m);
        begin
            case (m)
                4'd2:                              days_in = lp ? 5'd29 : 5'd28;
                4'd4, 4'd6, 4'd9, 4'd11:           days_in = 5'd30;
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
                4'd10, 4'd12:                      days_in = 5'd31;
                default:                           days_in = 5'd0;
            endcase
        end
    endfunction

    // days before the first of month m in a common year
    function automatic logic [8:0] cum_days(input logic [3:0] m);
        begin
            case (m)
                4'd1:    cum_days = 9'd0;
                4'd2:    cum_days = 9'd31;
                4'd3:    cum_days = 9'd59;
                4'd4:    cum_days = 9'd90;
                4'd5:    cum_days = 9'd120;
                4'd6:    cum_days = 9'd151;
                4'd7:    cum_days = 9'd181;
                4'd8:    cum_days = 9'd212;
                4'd9:    cum_days = 9'd243;
                4'd10:   cum_days = 9'd273;
                4'd11:   cum_days = 9'd304;
                4'd12:   cum_days = 9'd334;
                default: cum_days = 9'd0;
            endcase
        end
    endfunction

endpackage

`default_nettype wire

[rtl/gda_ctrl.sv]
// sequencer for the gregorian date arithmetic block
// depends on gda_pkg and gregorian_date_arithmetic_macros.svh
`default_nettype none
`include "gregorian_date_arithmetic_macros.svh"

module gda_ctrl
    import gda_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire gda_stat_t stat,
    output logic           busy,
    output logic           done,
    output gda_cmd_t       cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_MUL   = 15'h0002,
        S_CHECK = 15'h0004,
        S_NUM   = 15'h0008,
        S_OTHER = 15'h0010,
        S_DIFF  = 15'h0020,
        S_ARITH = 15'h0040,
        S_D400  = 15'h0080,
        S_D100  = 15'h0100,
        S_D4    = 15'h0200,
        S_D1    = 15'h0400,
        S_LEAPQ = 15'h0800,
        S_LEAP  = 15'h1000,
        S_MON   = 15'h2000,
        S_OUT   = 15'h4000
    } state_t;

    state_t state_reg, state_next;
    logic   second_reg, second_next;
    logic   done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            second_reg <= second_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        second_next = second_reg;
        done_next   = 1'b0;
        cmd.op      = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op      = OP_LOAD;
                    state_next  = S_MUL;
                    second_next = 1'b0;
                end
            end
            S_MUL:
            begin
                cmd.op     = OP_MUL;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.op     = OP_CHECK;
                state_next = S_NUM;
            end
            S_NUM:
            begin
                cmd.op = OP_NUM;
                if (!stat.is_diff)
                    state_next = S_ARITH;
                else if (second_reg)
                    state_next = S_DIFF;
                else
                    state_next = S_OTHER;
            end
            S_OTHER:
            begin
                cmd.op      = OP_OTHER;
                second_next = 1'b1;
                state_next  = S_MUL;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_OUT;
            end
            S_ARITH:
            begin
                cmd.op     = OP_ARITH;
                state_next = S_D400;
            end
            S_D400:
            begin
                cmd.op = OP_D400;
                if (!stat.go400)
                    state_next = S_D100;
            end
            S_D100:
            begin
                cmd.op = OP_D100;
                if (!stat.go100)
                    state_next = S_D4;
            end
            S_D4:
            begin
                cmd.op = OP_D4;
                if (!stat.go4)
                    state_next = S_D1;
            end
            S_D1:
            begin
                cmd.op = OP_D1;
                if (!stat.go1)
                    state_next = S_LEAPQ;
            end
            S_LEAPQ:
            begin
                cmd.op     = OP_LEAPQ;
                state_next = S_LEAP;
            end
            S_LEAP:
            begin
                cmd.op     = OP_LEAP;
                state_next = S_MON;
            end
            S_MON:
            begin
                cmd.op = OP_MON;
                if (!stat.gomon)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.op     = OP_FINISH;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    `GDA_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_reg))
    `GDA_ASSERT_IMP(a_done_after_out, done_reg, $past(state_reg) == S_OUT)
    `GDA_ASSERT_NXT(a_accept_starts, start && !busy, state_reg == S_MUL)

endmodule

`default_nettype wire

[rtl/gda_dpath.sv]
// datapath of the gregorian date arithmetic block: date to day number, offset
// arithmetic or difference, and day number back to date by repeated subtraction
// depends on gda_pkg and gregorian_date_arithmetic_macros.svh
`default_nettype none
`include "gregorian_date_arithmetic_macros.svh"

module gda_dpath
    import gda_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire gda_in_t  item,
    input  wire gda_cmd_t cmd,
    output gda_stat_t     stat,
    output gda_out_t      result
);

    logic [1:0]       act_reg, act_next;
    logic [19:0]      off_reg, off_next;
    logic [13:0]      oy_reg, oy_next;
    logic [3:0]       om_reg, om_next;
    logic [4:0]       od_reg, od_next;
    logic [13:0]      cy_reg, cy_next;
    logic [3:0]       cm_reg, cm_next;
    logic [4:0]       cd_reg, cd_next;
    logic [13:0]      p_reg, p_next;
    logic [NUM_W-1:0] p365_reg, p365_next;
    logic [7:0]       pq_reg, pq_next;
    logic [7:0]       yq_reg, yq_next;
    logic             leap_reg, leap_next;
    logic             valid_reg, valid_next;
    logic [NUM_W-1:0] yb_reg, yb_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0] a_reg, a_next;
    logic [NUM_W-1:0] r_reg, r_next;
    logic [NUM_W-1:0] cnt_reg, cnt_next;
    logic [13:0]      yy_reg, yy_next;
    logic [3:0]       mm_reg, mm_next;
    logic [1:0]       stp_reg, stp_next;
    logic             inv_reg, inv_next;
    logic             sat_reg, sat_next;
    gda_out_t         res_reg, res_next;

    logic [13:0]        p_w;
    logic [22:0]        p365_full;
    logic [26:0]        pq_full;
    logic [26:0]        yq_full;
    logic [26:0]        yyq_full;
    logic               leap_w;
    logic [4:0]         dim_w;
    logic [4:0]         mlen_w;
    logic signed [23:0] sum_w;
    logic [NUM_W-1:0]   diff_w;

    // shared products, all against constants
    assign p_w       = cy_reg - 14'd1;
    assign p365_full = {9'b0, p_w} * 23'(YEAR_LEN);
    assign pq_full   = {13'b0, p_w} * 27'(RECIP100);
    assign yq_full   = {13'b0, cy_reg} * 27'(RECIP100);
    assign yyq_full  = {13'b0, yy_reg} * 27'(RECIP100);
    assign leap_w    = leap_of(cy_reg, yq_reg);
    assign dim_w     = days_in(leap_w, cm_reg);
    assign mlen_w    = days_in(leap_reg, mm_reg);

    always_comb
    begin
        case (act_reg)
            ACT_ADD: sum_w = $signed({2'b0, num_reg}) + $signed({4'b0, off_reg});
            ACT_SUB: sum_w = $signed({2'b0, num_reg}) - $signed({4'b0, off_reg});
            default: sum_w = $signed({2'b0, num_reg});
        endcase
    end

    assign diff_w = (a_reg > num_reg) ? (a_reg - num_reg) : (num_reg - a_reg);

    assign stat.is_diff = (act_reg == ACT_DIFF);
    assign stat.go400   = (r_reg >= NUM_W'(CYC400));
    assign stat.go100   = (r_reg >= NUM_W'(CYC100)) && (stp_reg != 2'd3);
    assign stat.go4     = (r_reg >= NUM_W'(CYC4));
    assign stat.go1     = (r_reg >= NUM_W'(YEAR_LEN)) && (stp_reg != 2'd3);
    assign stat.gomon   = (r_reg >= {17'b0, mlen_w}) && (mm_reg < 4'd12);

    always_comb
    begin
        act_next   = act_reg;
        off_next   = off_reg;
        oy_next    = oy_reg;
        om_next    = om_reg;
        od_next    = od_reg;
        cy_next    = cy_reg;
        cm_next    = cm_reg;
        cd_next    = cd_reg;
        p_next     = p_reg;
        p365_next  = p365_reg;
        pq_next    = pq_reg;
        yq_next    = yq_reg;
        leap_next  = leap_reg;
        valid_next = valid_reg;
        yb_next    = yb_reg;
        num_next   = num_reg;
        a_next     = a_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        yy_next    = yy_reg;
        mm_next    = mm_reg;
        stp_next   = stp_reg;
        inv_next   = inv_reg;
        sat_next   = sat_reg;
        res_next   = res_reg;
        case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LOAD:
            begin
                act_next = item.action;
                off_next = item.offset_days;
                oy_next  = item.other_year;
                om_next  = item.other_month;
                od_next  = item.other_day;
                cy_next  = item.year;
                cm_next  = item.month;
                cd_next  = item.day;
                inv_next = 1'b0;
                sat_next = 1'b0;
            end
            OP_MUL:
            begin
                p_next    = p_w;
                p365_next = p365_full[NUM_W-1:0];
                pq_next   = pq_full[26:RECIP_SH];
                yq_next   = yq_full[26:RECIP_SH];
            end
            OP_CHECK:
            begin
                leap_next  = leap_w;
                valid_next = (cy_reg != 14'd0) && (cy_reg <= 14'(MAX_YEAR))
                             && (cm_reg != 4'd0) && (cm_reg <= 4'd12)
                             && (cd_reg != 5'd0) && (cd_reg <= dim_w);
                // days before 1 january of the year
                yb_next    = p365_reg + {10'b0, p_reg[13:2]} - {14'b0, pq_reg}
                             + {16'b0, pq_reg[7:2]};
            end
            OP_NUM:
            begin
                if (valid_reg)
                    num_next = yb_reg + {13'b0, cum_days(cm_reg)}
                               + {21'b0, leap_reg && (cm_reg > 4'd2)}
                               + {17'b0, cd_reg} - 22'd1;
                else
                begin
                    num_next = NUM_W'(REPL_NUM);
                    inv_next = 1'b1;
                end
            end
            OP_OTHER:
            begin
                a_next  = num_reg;
                cy_next = oy_reg;
                cm_next = om_reg;
                cd_next = od_reg;
            end
            OP_DIFF:
            begin
                if ({1'b0, diff_w} > 23'(COUNT_MAX))
                begin
                    cnt_next = NUM_W'(COUNT_MAX);
                    sat_next = 1'b1;
                end
                else
                    cnt_next = diff_w;
            end
            OP_ARITH:
            begin
                yy_next  = 14'd1;
                mm_next  = 4'd1;
                stp_next = 2'd0;
                if (sum_w > $signed(24'(LIMIT_NUM)))
                begin
                    r_next   = NUM_W'(LIMIT_NUM);
                    sat_next = 1'b1;
                end
                else if (sum_w < $signed(24'd0))
                begin
                    r_next   = '0;
                    sat_next = 1'b1;
                end
                else
                    r_next = sum_w[NUM_W-1:0];
            end
            OP_D400:
            begin
                if (stat.go400)
                begin
                    r_next  = r_reg - NUM_W'(CYC400);
                    yy_next = yy_reg + 14'd400;
                end
            end
            OP_D100:
            begin
                if (stat.go100)
                begin
                    r_next   = r_reg - NUM_W'(CYC100);
                    yy_next  = yy_reg + 14'd100;
                    stp_next = stp_reg + 2'd1;
                end
            end
            OP_D4:
            begin
                stp_next = 2'd0;
                if (stat.go4)
                begin
                    r_next  = r_reg - NUM_W'(CYC4);
                    yy_next = yy_reg + 14'd4;
                end
            end
            OP_D1:
            begin
                if (stat.go1)
                begin
                    r_next   = r_reg - NUM_W'(YEAR_LEN);
                    yy_next  = yy_reg + 14'd1;
                    stp_next = stp_reg + 2'd1;
                end
            end
            OP_LEAPQ:
            begin
                yq_next = yyq_full[26:RECIP_SH];
            end
            OP_LEAP:
            begin
                leap_next = leap_of(yy_reg, yq_reg);
            end
            OP_MON:
            begin
                if (stat.gomon)
                begin
                    r_next  = r_reg - {17'b0, mlen_w};
                    mm_next = mm_reg + 4'd1;
                end
            end
            OP_FINISH:
            begin
                if (act_reg == ACT_DIFF)
                begin
                    res_next.res_year  = '0;
                    res_next.res_month = '0;
                    res_next.res_day   = '0;
                    res_next.day_count = cnt_reg;
                end
                else
                begin
                    res_next.res_year  = yy_reg;
                    res_next.res_month = mm_reg;
                    res_next.res_day   = r_reg[4:0] + 5'd1;
                    res_next.day_count = '0;
                end
                res_next.status = sat_reg ? ST_SAT : (inv_reg ? ST_INVALID : ST_OK);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stp_reg <= 2'd0;
        else
            stp_reg <= stp_next;
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        off_reg   <= off_next;
        oy_reg    <= oy_next;
        om_reg    <= om_next;
        od_reg    <= od_next;
        cy_reg    <= cy_next;
        cm_reg    <= cm_next;
        cd_reg    <= cd_next;
        p_reg     <= p_next;
        p365_reg  <= p365_next;
        pq_reg    <= pq_next;
        yq_reg    <= yq_next;
        leap_reg  <= leap_next;
        valid_reg <= valid_next;
        yb_reg    <= yb_next;
        num_reg   <= num_next;
        a_reg     <= a_next;
        r_reg     <= r_next;
        cnt_reg   <= cnt_next;
        yy_reg    <= yy_next;
        mm_reg    <= mm_next;
        inv_reg   <= inv_next;
        sat_reg   <= sat_next;
        res_reg   <= res_next;
    end

    assign result = res_reg;

    `GDA_ASSERT_IMP(a_d1_below_cycle4, cmd.op == OP_D1, r_reg < NUM_W'(CYC4))
    `GDA_ASSERT_IMP(a_mon_below_year, cmd.op == OP_MON, r_reg <= NUM_W'(YEAR_LEN))
    `GDA_ASSERT_IMP(a_finish_month_ok, (cmd.op == OP_FINISH) && !stat.is_diff,
                    (mm_reg >= 4'd1) && (mm_reg <= 4'd12))

endmodule

`default_nettype wire

[rtl/gregorian_date_arithmetic.sv]
// top level of the gregorian date arithmetic block
// depends on gda_pkg, gda_ctrl and gda_dpath
//
//  channel   handshake            beat payload
//  item      start in, busy out   gda_in_t  (action, first date, offset, second date)
//  result    done out             gda_out_t (date, day count, status)
//
// a beat is taken at an edge with start high and busy low. add and subtract keep busy
// high while the date is turned into a day number, the offset is applied, 400, 100,
// 4 and 1 year blocks and then months are peeled off in loops that each end with a
// closing step, the leap test is made and the result is latched. a difference keeps
// busy high while both dates are converted, compared and the result is latched.
// done is high for one cycle with the result in the first cycle with busy low; the
// receiver cannot stall, and the next beat may be taken in that same cycle.
// reset clears the sequencer and the datapath step counter only.
`default_nettype none

module gregorian_date_arithmetic
    import gda_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire gda_in_t item,
    output logic         done,
    output gda_out_t     result
);

    // command to the datapath, one operation per cycle
    gda_cmd_t  cmd;
    // loop conditions and action kind back to the sequencer
    gda_stat_t stat;

    gda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    gda_dpath u_dpath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

`default_nettype wire

[tb/tb_gregorian_date_arithmetic.sv]
// self-checking testbench for the gregorian date arithmetic block
// holds a scoreboard class with its own calendar predictor; drives start/item, watches done
// depends on gda_pkg and the gregorian_date_arithmetic rtl
`default_nettype none

module tb_gregorian_date_arithmetic;
    timeunit 1ns;
    timeprecision 1ps;

    import gda_pkg::*;

    // spare action code, the block treats it as an add of zero days
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RANDOM_BEATS = 1700;
    // cycles to wait after the last result, well above the slowest add
    localparam int SETTLE_CYCLES = 100;
    localparam int DRAIN_LIMIT = 2000;

    // scoreboard: predicts each answer from the request beat and checks
    // answers in order against the queue of predictions
    class date_scoreboard;
        gda_out_t pending_answers[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned month_len(int unsigned y, int unsigned m);
            case (m)
                2:             return is_leap(y) ? 29 : 28;
                4, 6, 9, 11:   return 30;
                1, 3, 5, 7, 8,
                10, 12:        return 31;
                default:       return 0;
            endcase
        endfunction

        // swaps a bad date for the first of january 1900, returns 1 if it did
        function bit replace_bad_date(inout int unsigned y, inout int unsigned m,
                                      inout int unsigned d);
            if (y >= 1 && y <= MAX_YEAR && m >= 1 && m <= 12 && d >= 1
                    && d <= month_len(y, m))
                return 1'b0;
            y = REPL_YEAR;
            m = 1;
            d = 1;
            return 1'b1;
        endfunction

        // linear day count from the first of january of year 1
        function longint day_number(int unsigned y, int unsigned m, int unsigned d);
            longint p;
            longint n;
            p = y - 1;
            n = p * YEAR_LEN + p / 4 - p / 100 + p / 400;
            for (int unsigned i = 1; i < m; i++)
                n += month_len(y, i);
            return n + d - 1;
        endfunction

        function void number_to_date(longint n, output int unsigned y,
                                     output int unsigned m, output int unsigned d);
            longint unsigned r;
            longint unsigned c400;
            longint unsigned c100;
            longint unsigned c4;
            longint unsigned c1;
            int unsigned len;
            r = n;
            c400 = r / CYC400;
            r = r % CYC400;
            c100 = r / CYC100;
            // last day of a 400 year cycle belongs to the fourth century
            if (c100 > 3)
                c100 = 3;
            r -= c100 * CYC100;
            c4 = r / CYC4;
            r = r % CYC4;
            c1 = r / YEAR_LEN;
            if (c1 > 3)
                c1 = 3;
            r -= c1 * YEAR_LEN;
            y = int'(c400 * 400 + c100 * 100 + c4 * 4 + c1 + 1);
            m = 1;
            len = month_len(y, m);
            while (r >= len && m < 12)
            begin
                r -= len;
                m++;
                len = month_len(y, m);
            end
            d = int'(r) + 1;
        endfunction

        function gda_out_t calc_answer(gda_in_t req);
            gda_out_t ans;
            int unsigned y, m, d, oy, om, od, ry, rm, rd;
            longint a, b, lim, span;
            ans = '0;
            y = req.year;
            m = req.month;
            d = req.day;
            if (replace_bad_date(y, m, d))
                ans.status = ST_INVALID;
            a = day_number(y, m, d);
            if (req.action == ACT_DIFF)
            begin
                oy = req.other_year;
                om = req.other_month;
                od = req.other_day;
                if (replace_bad_date(oy, om, od))
                    ans.status = ST_INVALID;
                b = day_number(oy, om, od);
                span = (a > b) ? a - b : b - a;
                if (span > COUNT_MAX)
                begin
                    span = COUNT_MAX;
                    ans.status = ST_SAT;
                end
                ans.day_count = 22'(span);
            end
            else
            begin
                lim = day_number(MAX_YEAR, 12, 31);
                if (req.action == ACT_ADD)
                    a += longint'(req.offset_days);
                else if (req.action == ACT_SUB)
                    a -= longint'(req.offset_days);
                if (a > lim)
                begin
                    a = lim;
                    ans.status = ST_SAT;
                end
                else if (a < 0)
                begin
                    a = 0;
                    ans.status = ST_SAT;
                end
                number_to_date(a, ry, rm, rd);
                ans.res_year = 14'(ry);
                ans.res_month = 4'(rm);
                ans.res_day = 5'(rd);
            end
            return ans;
        endfunction

        function void note_request(gda_in_t req);
            pending_answers.push_back(calc_answer(req));
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction

        task report(string what, longint got, longint want);
            $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_answer(gda_out_t got);
            gda_out_t want;
            if (pending_answers.size() == 0)
            begin
                report("answer with no request outstanding", got.status, 0);
                return;
            end
            want = pending_answers.pop_front();
            if (got.res_year != want.res_year)
                report("res_year", got.res_year, want.res_year);
            if (got.res_month != want.res_month)
                report("res_month", got.res_month, want.res_month);
            if (got.res_day != want.res_day)
                report("res_day", got.res_day, want.res_day);
            if (got.day_count != want.day_count)
                report("day_count", got.day_count, want.day_count);
            if (got.status != want.status)
                report("status", got.status, want.status);
        endtask
    endclass

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    gda_in_t  item = '0;
    logic     done;
    gda_out_t result;

    date_scoreboard sb = new();
    // cleared for a long stretch so beats go back to back
    bit idle_on = 1'b1;

    gregorian_date_arithmetic u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // safety net against a hung handshake, several times the slowest run
    initial
    begin
        #8_000_000;
        $display("FAIL gregorian_date_arithmetic");
        $finish;
    end

    // answers are shown for one cycle only, take them at the edge ending it
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_answer(result);
    end

    function automatic gda_in_t mk(int act, int y, int m, int d, int off,
                                   int oy, int om, int od);
        gda_in_t r;
        r.action = 2'(act);
        r.year = 14'(y);
        r.month = 4'(m);
        r.day = 5'(d);
        r.offset_days = 20'(off);
        r.other_year = 14'(oy);
        r.other_month = 4'(om);
        r.other_day = 5'(od);
        return r;
    endfunction

    // one request beat: optional idle gap, then hold start until busy is low at an edge
    task send_request(gda_in_t req);
        if (idle_on)
        begin
            while ($urandom_range(99) < 12)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        item <= req;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(req);
    endtask

    // let every outstanding answer come home before the next beat
    task drain_answers();
        start <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    // a well-formed date, weighted towards the ends of the range and of months
    task pick_date(output logic [13:0] y, output logic [3:0] m, output logic [4:0] d);
        int unsigned len;
        case ($urandom_range(9))
            0:       y = 14'd1;
            1:       y = 14'(MAX_YEAR);
            2:       y = 14'(100 * $urandom_range(99, 1));
            default: y = 14'($urandom_range(MAX_YEAR, 1));
        endcase
        m = 4'($urandom_range(12, 1));
        len = sb.month_len(y, m);
        if ($urandom_range(3) == 0)
            d = 5'(len);
        else
            d = 5'($urandom_range(len, 1));
    endtask

    initial
    begin
        gda_in_t req;
        logic [95:0] noise;
        int unsigned len;
        int unsigned pick;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: range ends, leap rules, bad dates and both saturations
        send_request(mk(ACT_ADD, 1, 1, 1, 0, 1, 1, 1));
        send_request(mk(ACT_SUB, 1, 1, 1, 1, 0, 0, 0));
        send_request(mk(ACT_SUB, 1, 12, 31, 364, 0, 0, 0));
        send_request(mk(ACT_ADD, MAX_YEAR, 12, 30, 1, 0, 0, 0));
        send_request(mk(ACT_ADD, MAX_YEAR, 12, 31, 1, 0, 0, 0));
        send_request(mk(ACT_ADD, MAX_YEAR, 12, 31, 1048575, 16383, 15, 31));
        send_request(mk(ACT_SUB, MAX_YEAR, 12, 31, 1048575, 0, 0, 0));
        send_request(mk(ACT_ADD, 2000, 2, 28, 1, 0, 0, 0));
        send_request(mk(ACT_ADD, 1900, 2, 28, 1, 0, 0, 0));
        send_request(mk(ACT_ADD, 2024, 2, 29, 1, 0, 0, 0));
        send_request(mk(ACT_SUB, 2000, 3, 1, 1, 0, 0, 0));
        send_request(mk(ACT_ADD, 1999, 12, 31, 1, 0, 0, 0));
        // century without a leap day, month zero, month fifteen, year zero, day zero
        send_request(mk(ACT_ADD, 2100, 2, 29, 0, 0, 0, 0));
        send_request(mk(ACT_ADD, 2023, 0, 10, 5, 0, 0, 0));
        send_request(mk(ACT_ADD, 16383, 15, 31, 0, 0, 0, 0));
        send_request(mk(ACT_ADD, 0, 6, 15, 7, 0, 0, 0));
        send_request(mk(ACT_SUB, 2023, 6, 0, 7, 0, 0, 0));
        send_request(mk(ACT_ADD, 2023, 4, 31, 0, 0, 0, 0));
        send_request(mk(ACT_ADD, 10000, 1, 1, 0, 0, 0, 0));
        // replaced date that then runs off the bottom: saturation wins
        send_request(mk(ACT_SUB, 0, 0, 0, 1048575, 0, 0, 0));
        send_request(mk(ACT_DIFF, 1, 1, 1, 0, MAX_YEAR, 12, 31));
        send_request(mk(ACT_DIFF, MAX_YEAR, 12, 31, 1048575, 1, 1, 1));
        send_request(mk(ACT_DIFF, 1900, 1, 1, 0, 2001, 2, 29));
        send_request(mk(ACT_DIFF, 2023, 7, 14, 0, 2023, 7, 14));
        send_request(mk(ACT_SPARE, 2023, 12, 31, 12345, 0, 0, 0));
        drain_answers();

        // random beats, mostly well-formed with random content
        for (int k = 0; k < RANDOM_BEATS; k++)
        begin
            idle_on = !(k >= 700 && k < 1000);
            if (k == 850)
                drain_answers();
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                // raw noise over every field bit
                noise = {$urandom, $urandom, $urandom};
                req = noise[$bits(gda_in_t)-1:0];
            end
            else
            begin
                pick_date(req.year, req.month, req.day);
                pick_date(req.other_year, req.other_month, req.other_day);
                case ($urandom_range(3))
                    0:       req.offset_days = 20'($urandom_range(40));
                    1:       req.offset_days = 20'($urandom_range(1000));
                    2:       req.offset_days = 20'($urandom_range(100000));
                    default: req.offset_days = 20'($urandom_range(1048575));
                endcase
                pick = $urandom_range(99);
                if (pick < 5)
                    req.action = ACT_SPARE;
                else if (pick < 37)
                    req.action = ACT_ADD;
                else if (pick < 69)
                    req.action = ACT_SUB;
                else
                    req.action = ACT_DIFF;
                // a broken date now and then, one field spoilt
                if ($urandom_range(99) < 10)
                begin
                    case ($urandom_range(2))
                        0: req.year = $urandom_range(1) ? 14'd0
                                      : 14'($urandom_range(16383, MAX_YEAR + 1));
                        1: req.month = $urandom_range(1) ? 4'd0
                                       : 4'($urandom_range(15, 13));
                        default:
                        begin
                            len = sb.month_len(req.year, req.month);
                            req.day = (len == 31 || $urandom_range(1)) ? 5'd0
                                      : 5'($urandom_range(31, len + 1));
                        end
                    endcase
                end
            end
            send_request(req);
        end
        start <= 1'b0;

        for (int n = 0; n < DRAIN_LIMIT && sb.outstanding() != 0; n++)
            @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report("answers never arrived", sb.outstanding(), 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("PASS gregorian_date_arithmetic");
        else
            $display("FAIL gregorian_date_arithmetic");
        $finish;
    end

endmodule

`default_nettype wire
